### src/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the trapezoid setpoint profiler
// Fixed-point widths, register codes, multiplier sizing and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsp_pkg;

	// Field widths (positions Q31.16, velocity Q23.8)
	localparam int POS_W = 48;
	localparam int VEL_W = 32;
	localparam int ERR_W = POS_W + 1;
	localparam int NP_W  = POS_W + 2;
	localparam int MV_W  = 31;
	localparam int ACC_W = 36;
	localparam int TP_W  = 24;
	localparam int DV_W  = 41;

	// Configuration port
	localparam int CFG_W     = 36;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ACC_LIMIT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = CFG_IDX_W'(2);
	localparam logic [TP_W-1:0]      TP_RESET        = TP_W'(16777);

	// Digit-serial multiplier sizing
	localparam int MUL_A_W    = 48;
	localparam int MUL_B_W    = 36;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int DIGIT_W    = 4;
	localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
	localparam int CNT_W      = $clog2(MUL_DIGITS);

	// Product slices: a*dt is Q.28 >> 20, step is Q.32 >> 16
	localparam int ADT_W       = 40;
	localparam int ADT_LSB     = 20;
	localparam int V2_W        = 62;
	localparam int SM_W        = 40;
	localparam int STEP_LSB    = 16;
	localparam int BRAKE_SHIFT = 3;

	// Half a count in Q31.16
	localparam logic [POS_W-1:0] HALF_COUNT = POS_W'(32768);

	typedef enum logic [1:0] {
		MSEL_ADT,
		MSEL_V2,
		MSEL_EA,
		MSEL_STEP
	} mul_sel_t;

	typedef struct packed {
		logic [MV_W-1:0]  vel_limit;
		logic [ACC_W-1:0] acc_limit;
		logic [TP_W-1:0]  tick_period;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] setpoint;
		logic signed [VEL_W-1:0] velocity;
		logic                    done_res;
	} result_t;

	typedef struct packed {
		logic     hold;
		logic     advance;
		logic     snap;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     vel_update;
		logic     pos_update;
	} dp_cmd_t;

	typedef struct packed {
		logic fresh;
		logic op;
		logic disabled;
		logic mul_busy;
		logic mul_done;
		logic settled;
		logic overshoot;
	} dp_sts_t;

endpackage

### src/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_if: request and result channels of the trapezoid setpoint profiler
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tsp_in_if;
	import tsp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic signed [POS_W-1:0] goal_position;
	logic                    feedback_fresh;

	modport source (output valid, op, goal_position, feedback_fresh, input ready);
	modport sink   (input valid, op, goal_position, feedback_fresh, output ready);
endinterface

interface tsp_out_if;
	import tsp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] setpoint;
	logic signed [VEL_W-1:0] velocity;
	logic                    done_res;

	modport source (output valid, setpoint, velocity, done_res, input ready);
	modport sink   (input valid, setpoint, velocity, done_res, output ready);
endinterface

### src/tsp_mul.sv
// ----------------------------------------------------------------------------
// tsp_mul: digit-serial unsigned multiplier
// Retires four multiplier bits per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module tsp_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsp_pkg::MUL_A_W-1:0] a,
	input  logic [tsp_pkg::MUL_B_W-1:0] b,
	output logic                        busy,
	output logic                        done,
	output logic [tsp_pkg::MUL_P_W-1:0] prod
);
	import tsp_pkg::*;

	logic [MUL_A_W-1:0]         a_q;
	logic [MUL_B_W-1:0]         b_q;
	logic [MUL_P_W-1:0]         acc_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [DIGIT_W-1:0]         digit;
	logic [MUL_A_W+DIGIT_W-1:0] part;
	logic [MUL_P_W-1:0]         acc_d;

	// Shift the sum one digit and add the next partial product
	assign digit = b_q[MUL_B_W-1 -: DIGIT_W];
	assign part  = (MUL_A_W+DIGIT_W)'(a_q) * (MUL_A_W+DIGIT_W)'(digit);
	assign acc_d = (acc_q << DIGIT_W) + MUL_P_W'(part);

	// Sequence the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MUL_DIGITS - 1);
		end else if (busy_q) begin
			busy_q <= (cnt_q != '0);
			done_q <= (cnt_q == '0);
			cnt_q  <= cnt_q - CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// Hold operands and the running sum
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << DIGIT_W;
			acc_q <= acc_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

endmodule

### src/tsp_datapath.sv
// ----------------------------------------------------------------------------
// tsp_datapath: profile state and arithmetic
// Holds goal, setpoint and velocity, the intermediate terms of one tick, and
// the shared multiplier that forms a*dt, v*v, |e|*a and the position step.
// ----------------------------------------------------------------------------
module tsp_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsp_pkg::cfg_t                    cfg,
	input  logic                             in_capture,
	input  logic                             in_op,
	input  logic signed [tsp_pkg::POS_W-1:0] in_pos,
	input  logic                             in_fresh,
	input  tsp_pkg::dp_cmd_t                 cmd,
	output tsp_pkg::dp_sts_t                 sts,
	output tsp_pkg::result_t                 res
);
	import tsp_pkg::*;

	localparam logic signed [NP_W-1:0] NP_MAX =
		$signed({{(NP_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
	localparam logic signed [NP_W-1:0] NP_MIN = ~NP_MAX;

	// Request and profile state
	logic signed [POS_W-1:0] pos_q;
	logic                    op_q;
	logic                    fresh_q;
	logic signed [POS_W-1:0] goal_q;
	logic signed [POS_W-1:0] sp_q;
	logic signed [VEL_W-1:0] vel_q;

	// Per-tick terms
	logic                    err_neg_q;
	logic [POS_W-1:0]        abse_q;
	logic [ADT_W-1:0]        adt_q;
	logic [V2_W-1:0]         v2_q;
	logic                    brake_q;
	logic [SM_W-1:0]         sm_q;
	mul_sel_t                sel_q;

	logic signed [ERR_W-1:0] err_d;
	logic [POS_W-1:0]        abse_d;
	logic [VEL_W-1:0]        vel_mag;

	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic                    mul_busy;
	logic                    mul_done;
	logic [MUL_P_W-1:0]      mul_prod;

	logic signed [DV_W-1:0]  mv_s;
	logic signed [DV_W-1:0]  adt_s;
	logic signed [DV_W-1:0]  vel_ext;
	logic signed [DV_W-1:0]  desired;
	logic signed [DV_W-1:0]  delta_raw;
	logic signed [DV_W-1:0]  delta;
	logic signed [DV_W-1:0]  vel_new;

	logic signed [NP_W-1:0]  sm_s;
	logic signed [NP_W-1:0]  np;

	// Error toward the new goal and its magnitude
	assign err_d   = ERR_W'(pos_q) - ERR_W'(sp_q);
	assign abse_d  = err_d[ERR_W-1] ? POS_W'($unsigned(-err_d)) : POS_W'($unsigned(err_d));
	assign vel_mag = vel_q[VEL_W-1] ? $unsigned(-vel_q) : $unsigned(vel_q);

	// Pick multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_ADT: begin
				mul_a = MUL_A_W'(cfg.acc_limit);
				mul_b = MUL_B_W'(cfg.tick_period);
			end
			MSEL_V2: begin
				mul_a = MUL_A_W'(vel_mag);
				mul_b = MUL_B_W'(vel_mag);
			end
			MSEL_EA: begin
				mul_a = MUL_A_W'(abse_q);
				mul_b = MUL_B_W'(cfg.acc_limit);
			end
			MSEL_STEP: begin
				mul_a = MUL_A_W'(vel_mag);
				mul_b = MUL_B_W'(cfg.tick_period);
			end
		endcase
	end

	tsp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Head for the limit, or for zero inside braking distance; clamp to a*dt
	assign mv_s      = $signed({(DV_W-MV_W)'(0), cfg.vel_limit});
	assign adt_s     = $signed({(DV_W-ADT_W)'(0), adt_q});
	assign vel_ext   = DV_W'(vel_q);
	assign desired   = brake_q ? '0 : (err_neg_q ? -mv_s : mv_s);
	assign delta_raw = desired - vel_ext;

	always_comb begin
		priority if (delta_raw > adt_s) begin
			delta = adt_s;
		end else if (delta_raw < -adt_s) begin
			delta = -adt_s;
		end else begin
			delta = delta_raw;
		end
	end

	assign vel_new = vel_ext + delta;

	// Step with the sign of the velocity
	assign sm_s = $signed({(NP_W-SM_W)'(0), sm_q});
	assign np   = NP_W'(sp_q) + (vel_q[VEL_W-1] ? -sm_s : sm_s);

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_capture) begin
			pos_q   <= in_pos;
			op_q    <= in_op;
			fresh_q <= in_fresh;
		end
	end

	// Update goal, setpoint and velocity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q <= '0;
			sp_q   <= '0;
			vel_q  <= '0;
		end else begin
			if (cmd.hold) begin
				goal_q <= pos_q;
				sp_q   <= pos_q;
				vel_q  <= '0;
			end
			if (cmd.advance) begin
				goal_q <= pos_q;
			end
			if (cmd.snap) begin
				sp_q  <= goal_q;
				vel_q <= '0;
			end
			if (cmd.vel_update) begin
				vel_q <= VEL_W'(vel_new);
			end
			if (cmd.pos_update) begin
				priority if (np > NP_MAX) begin
					sp_q <= POS_W'(NP_MAX);
				end else if (np < NP_MIN) begin
					sp_q <= POS_W'(NP_MIN);
				end else begin
					sp_q <= POS_W'(np);
				end
			end
		end
	end

	// Track which product is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= MSEL_ADT;
		end else if (cmd.mul_start) begin
			sel_q <= cmd.mul_sel;
		end
	end

	// Latch error terms and finished products
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			err_neg_q <= err_d[ERR_W-1];
			abse_q    <= abse_d;
		end
		if (mul_done) begin
			unique case (sel_q)
				MSEL_ADT:  adt_q   <= mul_prod[ADT_LSB +: ADT_W];
				MSEL_V2:   v2_q    <= mul_prod[V2_W-1:0];
				MSEL_EA:   brake_q <= (mul_prod <= (MUL_P_W'(v2_q) << BRAKE_SHIFT));
				MSEL_STEP: sm_q    <= mul_prod[STEP_LSB +: SM_W];
			endcase
		end
	end

	// Report status to the controller
	assign sts.fresh     = fresh_q;
	assign sts.op        = op_q;
	assign sts.disabled  = (cfg.vel_limit == '0) || (cfg.acc_limit == '0);
	assign sts.mul_busy  = mul_busy;
	assign sts.mul_done  = mul_done;
	assign sts.settled   = (abse_q < HALF_COUNT) && (ADT_W'(vel_mag) < adt_q);
	assign sts.overshoot = (POS_W'(sm_q) >= abse_q);

	assign res.setpoint = sp_q;
	assign res.velocity = vel_q;
	assign res.done_res = (goal_q == sp_q) && (vel_q == '0);

	// Hold and snap leave the profile at rest on the goal
	a_rest_after_snap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hold || cmd.snap) |=> (sp_q == goal_q && vel_q == '0))
		else $error("setpoint not at rest on goal after hold or snap");

endmodule

### src/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl: tick sequencer of the trapezoid setpoint profiler
// Walks one request through decision, up to four products and the state
// updates, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_free,
	input  tsp_pkg::dp_sts_t  sts,
	output logic              in_ready,
	output logic              out_load,
	output tsp_pkg::dp_cmd_t  cmd
);
	import tsp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SNAP,
		ST_ADT,
		ST_ADT_W,
		ST_SETTLE,
		ST_V2_W,
		ST_EA,
		ST_EA_W,
		ST_VEL,
		ST_STEP,
		ST_STEP_W,
		ST_POS,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode commands and next state
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (!sts.fresh) begin
					state_d = ST_FINISH;
				end else if (sts.op) begin
					cmd.hold = 1'b1;
					state_d  = ST_FINISH;
				end else begin
					cmd.advance = 1'b1;
					state_d     = sts.disabled ? ST_SNAP : ST_ADT;
				end
			end
			ST_SNAP: begin
				cmd.snap = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_ADT: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_ADT;
				state_d       = ST_ADT_W;
			end
			ST_ADT_W: begin
				if (sts.mul_done) state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				if (sts.settled) begin
					state_d = ST_SNAP;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_V2;
					state_d       = ST_V2_W;
				end
			end
			ST_V2_W: begin
				if (sts.mul_done) state_d = ST_EA;
			end
			ST_EA: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_EA;
				state_d       = ST_EA_W;
			end
			ST_EA_W: begin
				if (sts.mul_done) state_d = ST_VEL;
			end
			ST_VEL: begin
				cmd.vel_update = 1'b1;
				state_d        = ST_STEP;
			end
			ST_STEP: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_STEP;
				state_d       = ST_STEP_W;
			end
			ST_STEP_W: begin
				if (sts.mul_done) state_d = ST_POS;
			end
			ST_POS: begin
				if (sts.overshoot) begin
					state_d = ST_SNAP;
				end else begin
					cmd.pos_update = 1'b1;
					state_d        = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.hold, cmd.advance, cmd.snap, cmd.vel_update, cmd.pos_update}))
		else $error("more than one state update in a cycle");

endmodule

### src/trapezoid_setpoint_profiler_core.sv
// ----------------------------------------------------------------------------
// trapezoid_setpoint_profiler_core: trapezoidal setpoint profiler
// One request per control tick moves a profiled setpoint toward the goal with
// limited velocity and acceleration, or holds at a given position.
//
//   channel  | dir | payload                                 | handshake
//   ---------+-----+-----------------------------------------+------------
//   in_ch    | in  | op, goal_position, feedback_fresh       | valid/ready
//   out_ch   | out | setpoint, velocity, done_res            | valid/ready
//   cfg      | in  | cfg_index, cfg_wdata                    | cfg_we
//
// An advancing tick that is not settled forms four products on the shared
// multiplier, nine 4-bit digits each, and updates velocity and then
// position, or snaps to the goal on overshoot. A settled tick forms one
// product; a hold, stale or unprofiled tick forms none.
// One request is in work at a time; a new one is taken the cycle after its
// result enters the output register, which holds it while out_ch stalls.
// Reset clears the profile to zero.
// ----------------------------------------------------------------------------
module trapezoid_setpoint_profiler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsp_pkg::CFG_W-1:0]       cfg_wdata,
	tsp_in_if.sink                          in_ch,
	tsp_out_if.source                       out_ch
);
	import tsp_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;
	result_t res;
	logic    in_fire;
	logic    in_ready;
	logic    out_load;
	logic    out_free;
	logic    out_valid_q;
	result_t out_q;

	assign in_fire     = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vel_limit   <= '0;
			cfg_q.acc_limit   <= '0;
			cfg_q.tick_period <= TP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VEL_LIMIT:   cfg_q.vel_limit   <= cfg_wdata[MV_W-1:0];
				CFG_ACC_LIMIT:   cfg_q.acc_limit   <= cfg_wdata[ACC_W-1:0];
				CFG_TICK_PERIOD: cfg_q.tick_period <= cfg_wdata[TP_W-1:0];
				default: ;
			endcase
		end
	end

	tsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (in_ready),
		.out_load (out_load),
		.cmd      (cmd)
	);

	tsp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_capture (in_fire),
		.in_op      (in_ch.op),
		.in_pos     (in_ch.goal_position),
		.in_fresh   (in_ch.feedback_fresh),
		.cmd        (cmd),
		.sts        (sts),
		.res        (res)
	);

	// Output register: drop valid once taken, reload when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= res;
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.setpoint = out_q.setpoint;
	assign out_ch.velocity = out_q.velocity;
	assign out_ch.done_res = out_q.done_res;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready)
		else $error("request taken while another is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> ($stable(out_q) && out_valid_q))
		else $error("pending result overwritten");

endmodule

### tb/tb_trapezoid_setpoint_profiler_core.sv
// ----------------------------------------------------------------------------
// tb_trapezoid_setpoint_profiler_core: self-checking bench of the profiler
// Feeds control ticks through the request channel under random backpressure
// and idle gaps, predicts setpoint, velocity and done for every accepted tick
// from a local profile model, and checks each result in order. Covers the
// disabled, hold, stale, settled, overshoot and saturation paths, then random
// motion sequences over several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_trapezoid_setpoint_profiler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tsp_pkg::*;

	typedef struct packed {
		logic                    op;
		logic signed [POS_W-1:0] goal;
		logic                    fresh;
	} tick_t;

	localparam longint POS_HI = (64'sd1 <<< (POS_W - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tsp_in_if  in_ch ();
	tsp_out_if out_ch ();

	trapezoid_setpoint_profiler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Ticks waiting to be sent and results the profile is expected to report
	tick_t   tick_q[$];
	result_t profile_q[$];

	// Local copy of the profile state and registers
	longint goal_s  = 0;
	longint sp_s    = 0;
	longint vel_s   = 0;
	longint vmax_s  = 0;
	longint amax_s  = 0;
	longint dt_s    = longint'(TP_RESET);

	int unsigned n_err    = 0;
	int unsigned n_taken  = 0;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	int unsigned hold_cnt = 0;
	bit          calm     = 1'b0;
	tick_t       drv_tick;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint abs64(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random position: full 48-bit range or within about 2^23 counts
	function automatic longint rand_pos(input bit wide);
		logic [POS_W-1:0] w;
		w = POS_W'({$urandom(), $urandom()});
		if (wide)
			return longint'($signed(w));
		return longint'($signed(w)) >>> 8;
	endfunction

	// Advance the profile by one control tick
	function automatic void profile_tick(input tick_t t);
		longint err, adt, want, dv, sm, np, v2, q;
		bit     braking;
		if (!t.fresh)
			return;
		goal_s = longint'($signed(t.goal));
		if (t.op || vmax_s == 0 || amax_s == 0) begin
			sp_s  = goal_s;
			vel_s = 0;
			return;
		end
		err = goal_s - sp_s;
		adt = (amax_s * dt_s) >>> ADT_LSB;
		// settled: snap to goal
		if (abs64(err) < longint'(HALF_COUNT) && abs64(vel_s) < adt) begin
			sp_s  = goal_s;
			vel_s = 0;
			return;
		end
		// brake once the error is within v*v/(2a)
		v2 = abs64(vel_s) * abs64(vel_s);
		q  = v2 / amax_s;
		if (q >= (64'sd1 <<< 46))
			braking = 1'b1;
		else
			braking = abs64(err) <= 8 * q + (8 * (v2 % amax_s)) / amax_s;
		want = braking ? 0 : ((err >= 0) ? vmax_s : -vmax_s);
		dv   = want - vel_s;
		if (dv > adt)
			dv = adt;
		if (dv < -adt)
			dv = -adt;
		vel_s = vel_s + dv;
		sm = (abs64(vel_s) * dt_s) >>> STEP_LSB;
		// overshoot: snap to goal
		if (sm >= abs64(err)) begin
			sp_s  = goal_s;
			vel_s = 0;
			return;
		end
		np = sp_s + ((vel_s < 0) ? -sm : sm);
		if (np > POS_HI)
			np = POS_HI;
		if (np < POS_LO)
			np = POS_LO;
		sp_s = np;
	endfunction

	// Request driver: hold the request until taken, then idle or send the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid          <= 1'b0;
			in_ch.op             <= 1'b0;
			in_ch.goal_position  <= '0;
			in_ch.feedback_fresh <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				drv_tick = tick_q.pop_front();
				in_ch.valid          <= 1'b1;
				in_ch.op             <= drv_tick.op;
				in_ch.goal_position  <= drv_tick.goal;
				in_ch.feedback_fresh <= drv_tick.fresh;
				send_gap = pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, and a long hold-off now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_taken++;
				if (n_taken % 250 == 120)
					hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					take_gap = pick_gap();
			end
		end
	end

	// Monitor: track register writes, predict accepted ticks, check results
	always @(posedge clk) begin
		tick_t   t;
		result_t r;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_VEL_LIMIT:   vmax_s = longint'(cfg_wdata[MV_W-1:0]);
					CFG_ACC_LIMIT:   amax_s = longint'(cfg_wdata[ACC_W-1:0]);
					CFG_TICK_PERIOD: dt_s   = longint'(cfg_wdata[TP_W-1:0]);
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (profile_q.size() == 0) begin
					n_err++;
					$display("%0t: unexpected result: setpoint %0d velocity %0d done %0b",
						$time, out_ch.setpoint, out_ch.velocity, out_ch.done_res);
				end else begin
					r = profile_q.pop_front();
					if (out_ch.setpoint !== r.setpoint) begin
						n_err++;
						$display("%0t: setpoint expected %0d, actual %0d",
							$time, r.setpoint, out_ch.setpoint);
					end
					if (out_ch.velocity !== r.velocity) begin
						n_err++;
						$display("%0t: velocity expected %0d, actual %0d",
							$time, r.velocity, out_ch.velocity);
					end
					if (out_ch.done_res !== r.done_res) begin
						n_err++;
						$display("%0t: done_res expected %0b, actual %0b",
							$time, r.done_res, out_ch.done_res);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				t.op    = in_ch.op;
				t.goal  = in_ch.goal_position;
				t.fresh = in_ch.feedback_fresh;
				profile_tick(t);
				r.setpoint = sp_s[POS_W-1:0];
				r.velocity = vel_s[VEL_W-1:0];
				r.done_res = (goal_s == sp_s) && (vel_s == 0);
				profile_q.push_back(r);
			end
		end
	end

	task automatic push_tick(input logic op, input longint pos, input logic fresh);
		tick_t t;
		t.op    = op;
		t.goal  = pos[POS_W-1:0];
		t.fresh = fresh;
		tick_q.push_back(t);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_profile(input longint mv, input longint acc, input longint tp);
		write_reg(CFG_VEL_LIMIT, mv);
		write_reg(CFG_ACC_LIMIT, acc);
		write_reg(CFG_TICK_PERIOD, tp);
	endtask

	// Wait until every request is taken and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_ch.valid || profile_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stim
		longint      mv, acc, tp, est, base, goal, dir;
		int unsigned fresh_n, steps;
		bit          fr;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_VEL_LIMIT;
		cfg_wdata            = '0;
		in_ch.valid          = 1'b0;
		in_ch.op             = 1'b0;
		in_ch.goal_position  = '0;
		in_ch.feedback_fresh = 1'b0;
		out_ch.ready         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Profiling disabled after reset: jump to goal, stale and hold ticks
		push_tick(1'b0, POS_HI, 1'b1);
		push_tick(1'b0, POS_LO, 1'b1);
		push_tick(1'b0, 12345, 1'b0);
		push_tick(1'b1, -5, 1'b1);
		push_tick(1'b1, POS_HI, 1'b0);
		drain();

		// Fast profile: a*dt about a quarter of the velocity limit
		set_profile(64'h7FFF_FFFF, 64'sd1 <<< 25, 64'hFF_FFFF);
		push_tick(1'b1, 0, 1'b1);
		push_tick(1'b0, 40000, 1'b1);        // overshoot within one step
		push_tick(1'b0, 60000, 1'b1);        // settled under half a count
		push_tick(1'b0, -(64'sd1 <<< 44), 1'b1);
		push_tick(1'b0, -(64'sd1 <<< 44), 1'b1);
		push_tick(1'b0, 0, 1'b0);            // stale: goal must not change
		// Build speed near a range limit, then reverse the goal to saturate
		for (int s = 0; s < 2; s++) begin
			push_tick(1'b1, (s == 0) ? POS_HI - (64'sd1 <<< 40) :
				POS_LO + (64'sd1 <<< 40), 1'b1);
			repeat (3) push_tick(1'b0, (s == 0) ? POS_HI : POS_LO, 1'b1);
			repeat (3) push_tick(1'b0, (s == 0) ? POS_LO : POS_HI, 1'b1);
		end
		drain();

		// Random motion over several register settings
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					mv = 64'h7FFF_FFFF; acc = 64'hF_FFFF_FFFF; tp = 64'hFF_FFFF;
				end
				1: begin
					mv = 1; acc = 1; tp = 1;
				end
				2: begin
					mv = 0; acc = longint'($urandom()); tp = TP_RESET;
				end
				default: begin
					mv  = longint'($urandom() >> (1 + $urandom_range(0, 24)));
					acc = longint'({4'($urandom_range(0, 15)), $urandom()})
						>> $urandom_range(4, 35);
					tp  = longint'($urandom_range(1, 24'hFF_FFFF)) >> $urandom_range(0, 12);
					if (p == 5)
						acc = 0;
					if (tp == 0)
						tp = 1;
				end
			endcase
			drain();
			calm = (p == 3 || p == 6);
			set_profile(mv, acc, tp);
			est = (mv * tp) >>> STEP_LSB;
			if (est < 1)
				est = 1;
			fresh_n = 0;
			while (fresh_n < 64) begin
				if ($urandom_range(0, 9) < 7) begin
					// mostly hold somewhere, then advance toward a nearby goal
					base = rand_pos($urandom_range(0, 3) == 0);
					if ($urandom_range(0, 4) != 0) begin
						push_tick(1'b1, base, 1'b1);
						fresh_n++;
					end
					steps = $urandom_range(3, 20);
					for (int k = 0; k < steps; k++) begin
						if (k == 0 || $urandom_range(0, 7) == 0) begin
							dir  = $urandom_range(0, 1) ? 1 : -1;
							goal = base + dir * (est * $urandom_range(0, 12) +
								$urandom_range(0, 65535));
							if (goal > POS_HI)
								goal = POS_HI;
							if (goal < POS_LO)
								goal = POS_LO;
						end
						fr = ($urandom_range(0, 11) != 0);
						push_tick(1'b0, goal, fr);
						if (fr)
							fresh_n++;
					end
				end else begin
					// noise: any op, any position, any freshness
					fr = 1'($urandom_range(0, 1));
					push_tick(1'($urandom_range(0, 1)), rand_pos(1'b1), fr);
					if (fr)
						fresh_n++;
				end
			end
		end
		drain();
		calm = 1'b0;

		repeat (60) @(posedge clk);
		if (n_err == 0 && profile_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### trapezoid_setpoint_profiler_core.f
src/tsp_pkg.sv
src/tsp_if.sv
src/tsp_mul.sv
src/tsp_datapath.sv
src/tsp_ctrl.sv
src/trapezoid_setpoint_profiler_core.sv
tb/tb_trapezoid_setpoint_profiler_core.sv
